// ===== design/hpt_pkg.sv =====
// Package for the homography point transform: widths, register indexes
// and reset values shared by the channel interfaces and the top level.
// No dependencies.
`default_nettype none

package hpt_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int COEFF_WIDTH     = 21;
    localparam int COEFF_FRAC_BITS = 12;
    localparam int OUT_FRAC_BITS   = 8;
    localparam int OUT_WIDTH       = 32;
    localparam int CFG_WIDTH       = 63;
    localparam int CFG_IDX_WIDTH   = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2 = 2'd2;

    localparam logic [CFG_WIDTH-1:0] RESET_ROW0 = 63'd4096;
    localparam logic [CFG_WIDTH-1:0] RESET_ROW1 = 63'd8589934592;
    localparam logic [CFG_WIDTH-1:0] RESET_ROW2 = 63'd18014398509481984;

endpackage

`default_nettype wire

// ===== design/hpt_if.sv =====
// Valid/ready channel interfaces: input points, result points, register writes.
// Depends on hpt_pkg.
`default_nettype none

interface hpt_in_if;
    import hpt_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_w;
    modport source (output valid, mode, in_x, in_y, in_w, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_w, output ready);
endinterface

interface hpt_out_if;
    import hpt_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] out_x;
    logic signed [OUT_WIDTH-1:0] out_y;
    logic                        at_infinity;
    modport source (output valid, out_x, out_y, at_infinity, input ready);
    modport sink   (input valid, out_x, out_y, at_infinity, output ready);
endinterface

interface hpt_cfg_if;
    import hpt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [CFG_WIDTH-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/homography_point_transform.sv =====
// Homography point transform: 3x3 matrix step and rounded perspective divide.
// Depends on hpt_pkg and the channel interfaces in hpt_if.sv.
//
// Takes one homogeneous point per cycle while the output is not stalled and
// returns one Q23.8 point per transaction, in order. A result passes through
// one multiply stage, one sum stage, three stages that form magnitudes,
// scaled numerators and the overflow check, 31 divider stages (one quotient
// bit per stage, both coordinates in parallel) and the output register.
// Every stage holds independently when downstream stalls, so bubbles are
// squeezed out and throughput stays one point per cycle while o_pt.ready
// is high. Register writes land next cycle and are meant for idle periods.
`default_nettype none

module homography_point_transform (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hpt_in_if.sink     i_pt,
    hpt_out_if.source  o_pt,
    hpt_cfg_if.sink    i_cfg
);
    import hpt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int KW = COEFF_WIDTH;
    localparam int PW = CW + KW;
    localparam int AW = PW + 2;
    localparam int NW = AW + OUT_FRAC_BITS + 2;
    localparam int DW = AW + 1;
    localparam int QB = OUT_WIDTH - 1;

    localparam int ST_SUM = 1;
    localparam int ST_ABS = 2;
    localparam int ST_ND  = 3;
    localparam int ST_PRE = 4;
    localparam int ST_DIV = 5;
    localparam int ST_OUT = ST_DIV + QB;
    localparam int NS     = ST_OUT + 1;

    localparam logic signed [KW-1:0]    K_ONE   = KW'(1) << COEFF_FRAC_BITS;
    localparam logic [OUT_FRAC_BITS:0]  Z_PAD   = '0;
    localparam logic [OUT_WIDTH-1:0]    OUT_MAX = {1'b0, {QB{1'b1}}};
    localparam logic [OUT_WIDTH-1:0]    OUT_MIN = {1'b1, {QB{1'b0}}};

    // configuration
    logic [CFG_WIDTH-1:0] r_row [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= RESET_ROW0;
            r_row[1] <= RESET_ROW1;
            r_row[2] <= RESET_ROW2;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROW0: r_row[0] <= i_cfg.data;
                REG_ROW1: r_row[1] <= i_cfg.data;
                REG_ROW2: r_row[2] <= i_cfg.data;
                default:  ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its successor loads
    logic [NS:0]   w_en;
    logic [NS-1:0] r_valid;

    assign w_en[NS] = o_pt.ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = !r_valid[k] || w_en[k+1];
    end

    assign i_pt.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_pt.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // coefficient select: divide-only mode uses a scaled identity
    logic signed [KW-1:0] w_k   [3][3];
    logic signed [CW-1:0] w_xyw [3];

    always_comb begin
        w_xyw[0] = i_pt.in_x;
        w_xyw[1] = i_pt.in_y;
        w_xyw[2] = i_pt.in_w;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (i_pt.mode) begin
                    w_k[r][c] = (r == c) ? K_ONE : '0;
                end else begin
                    w_k[r][c] = r_row[r][c*KW +: KW];
                end
            end
        end
    end

    // payload registers
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [AW-1:0] r_sum  [3];
    logic [AW-1:0]        r_num  [2];
    logic [AW-1:0]        r_dmag;
    logic [1:0]           r_neg2;
    logic                 r_zero2;
    logic [NW-1:0]        r_nd   [2];
    logic [DW-1:0]        r_den3;
    logic [1:0]           r_neg3;
    logic                 r_zero3;

    logic [DW-1:0] r_rem [QB+1][2];
    logic [QB-1:0] r_lo  [QB+1][2];
    logic [QB-1:0] r_q   [QB+1][2];
    logic [1:0]    r_ovf [QB+1];
    logic [1:0]    r_ng  [QB+1];
    logic [DW-1:0] r_dv  [QB+1];
    logic          r_zr  [QB+1];

    logic [OUT_WIDTH-1:0] r_ox;
    logic [OUT_WIDTH-1:0] r_oy;
    logic                 r_oinf;

    // combinational helpers
    logic [AW-1:0]        w_mag  [3];
    logic [DW:0]          w_t    [QB][2];
    logic [DW-1:0]        w_rnx  [QB][2];
    logic                 w_ge   [QB][2];
    logic [OUT_WIDTH-1:0] w_res  [2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_mag[r] = r_sum[r][AW-1] ? AW'(-r_sum[r]) : AW'(r_sum[r]);
        end
        for (int j = 0; j < QB; j++) begin
            for (int l = 0; l < 2; l++) begin
                w_t[j][l]   = {r_rem[j][l], r_lo[j][l][QB-1]};
                w_ge[j][l]  = w_t[j][l] >= {1'b0, r_dv[j]};
                w_rnx[j][l] = w_ge[j][l] ? DW'(w_t[j][l] - {1'b0, r_dv[j]}) : DW'(w_t[j][l]);
            end
        end
        for (int l = 0; l < 2; l++) begin
            if (r_zr[QB]) begin
                w_res[l] = '0;
            end else if (r_ng[QB][l]) begin
                w_res[l] = r_ovf[QB][l] ? OUT_MIN : OUT_WIDTH'(-{1'b0, r_q[QB][l]});
            end else begin
                w_res[l] = r_ovf[QB][l] ? OUT_MAX : {1'b0, r_q[QB][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= w_k[r][c] * w_xyw[c];
                end
            end
        end
        if (w_en[ST_SUM]) begin
            for (int r = 0; r < 3; r++) begin
                r_sum[r] <= AW'(r_prod[r][0]) + AW'(r_prod[r][1]) + AW'(r_prod[r][2]);
            end
        end
        if (w_en[ST_ABS]) begin
            r_num[0] <= w_mag[0];
            r_num[1] <= w_mag[1];
            r_dmag   <= w_mag[2];
            r_neg2   <= {r_sum[1][AW-1] ^ r_sum[2][AW-1], r_sum[0][AW-1] ^ r_sum[2][AW-1]};
            r_zero2  <= (r_sum[2] == '0);
        end
        if (w_en[ST_ND]) begin
            // round half away: (n * 512 + d) / (2 * d)
            for (int l = 0; l < 2; l++) begin
                r_nd[l] <= NW'({r_num[l], Z_PAD}) + NW'(r_dmag);
            end
            r_den3  <= {r_dmag, 1'b0};
            r_neg3  <= r_neg2;
            r_zero3 <= r_zero2;
        end
        if (w_en[ST_PRE]) begin
            for (int l = 0; l < 2; l++) begin
                r_ovf[0][l] <= DW'(r_nd[l][NW-1:QB]) >= r_den3;
                r_rem[0][l] <= DW'(r_nd[l][NW-1:QB]);
                r_lo[0][l]  <= r_nd[l][QB-1:0];
                r_q[0][l]   <= '0;
            end
            r_dv[0] <= r_den3;
            r_ng[0] <= r_neg3;
            r_zr[0] <= r_zero3;
        end
        for (int j = 0; j < QB; j++) begin
            if (w_en[ST_DIV+j]) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[j+1][l] <= w_rnx[j][l];
                    r_lo[j+1][l]  <= {r_lo[j][l][QB-2:0], 1'b0};
                    r_q[j+1][l]   <= {r_q[j][l][QB-2:0], w_ge[j][l]};
                end
                r_ovf[j+1] <= r_ovf[j];
                r_dv[j+1]  <= r_dv[j];
                r_ng[j+1]  <= r_ng[j];
                r_zr[j+1]  <= r_zr[j];
            end
        end
        if (w_en[ST_OUT]) begin
            r_ox   <= w_res[0];
            r_oy   <= w_res[1];
            r_oinf <= r_zr[QB];
        end
    end

    assign o_pt.valid       = r_valid[ST_OUT];
    assign o_pt.out_x       = r_ox;
    assign o_pt.out_y       = r_oy;
    assign o_pt.at_infinity = r_oinf;

endmodule

`default_nettype wire
